### sv/b2da_pkg.sv
// Shared constants and types of the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

   // Word and digit geometry
   localparam int NumBits   = 32;
   localparam int NumDigits = 10;
   localparam int BcdBits   = 4 * NumDigits;
   localparam int PosBits   = $clog2(NumDigits);

   // Character codes
   localparam logic [6:0] CharMinus = 7'd45;
   localparam logic [6:0] CharZero  = 7'd48;

   // Data handed from one conversion cell to the next
   typedef struct packed {
      logic                  neg;
      logic [BcdBits-1:0]    bcd;
      logic [NumBits-1:0]    bin;
   } cell_data_type;

endpackage

`default_nettype wire

### sv/b2da_cell.sv
// One shift-and-add-3 cell of the binary to BCD conversion chain.
`default_nettype none

module b2da_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   enable,
   input  wire logic                   in_valid,
   input  wire b2da_pkg::cell_data_type in_data,
   output logic                        out_valid,
   output b2da_pkg::cell_data_type     out_data
);

   logic                    valid_ff;
   b2da_pkg::cell_data_type data_ff;
   b2da_pkg::cell_data_type data_in;
   logic [b2da_pkg::BcdBits-1:0] adj;

   // Correct each digit that would overflow on the shift, then shift one bit in
   always_comb begin
      for (int i = 0; i < b2da_pkg::NumDigits; i++) begin
         if (in_data.bcd[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = in_data.bcd[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = in_data.bcd[4*i +: 4];
         end
      end
      data_in.neg = in_data.neg;
      data_in.bcd = {adj[b2da_pkg::BcdBits-2:0], in_data.bin[b2da_pkg::NumBits-1]};
      data_in.bin = {in_data.bin[b2da_pkg::NumBits-2:0], 1'b0};
   end

   // Advance the valid bit with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload while the chain is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### sv/b2da_emit.sv
// Character serializer: sign, then digits without leading zeros.
`default_nettype none

module b2da_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire b2da_pkg::cell_data_type in_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [6:0]                   rsp_out_char,
   output logic                         rsp_last
);

   logic                         busy_ff, busy_in;
   logic                         sign_ff, sign_in;
   logic [b2da_pkg::PosBits-1:0] pos_ff, pos_in;
   logic [3:0]                   digit_ff [b2da_pkg::NumDigits];
   logic [b2da_pkg::PosBits-1:0] lead;
   logic                         take;
   logic                         load;

   // Find the most significant nonzero digit; zero keeps the units digit
   always_comb begin
      lead = '0;
      for (int i = 0; i < b2da_pkg::NumDigits; i++) begin
         if (in_data.bcd[4*i +: 4] != 4'd0) begin
            lead = b2da_pkg::PosBits'(i);
         end
      end
   end

   assign take     = busy_ff && rsp_ready;
   assign in_ready = !busy_ff || (take && rsp_last);
   assign load     = in_valid && in_ready;

   // Drive the current character
   assign rsp_valid    = busy_ff;
   assign rsp_last     = !sign_ff && (pos_ff == '0);
   assign rsp_out_char = sign_ff ? b2da_pkg::CharMinus
                                 : b2da_pkg::CharZero + {3'd0, digit_ff[pos_ff]};

   // Load a new number or step to the next character
   always_comb begin
      busy_in = busy_ff;
      sign_in = sign_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         sign_in = in_data.neg;
         pos_in  = lead;
      end else if (take) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else if (pos_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sign_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sign_ff <= sign_in;
         pos_ff  <= pos_in;
      end
   end

   // Capture the digits of the incoming number
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < b2da_pkg::NumDigits; i++) begin
            digit_ff[i] <= in_data.bcd[4*i +: 4];
         end
      end
   end

endmodule

`default_nettype wire

### sv/binary_to_decimal_ascii.sv
// Top level: 32-bit word to decimal ASCII text, one character per response.
//
//   channel  direction  payload                 handshake
//   req      in         req_func, req_value     req_valid / req_ready
//   rsp      out        rsp_out_char, rsp_last  rsp_valid / rsp_ready
//
// A request enters a chain of 32 shift-and-add-3 cells, one bit per cell,
// and passes through the register of each cell to the serializer; requests
// enter back to back while the chain is not stalled. The serializer sends
// 1 to 11 characters, one per cycle while rsp_ready is high.
// Reset clears the valid bit of every cell and the serializer; no sweep.
// The whole chain stalls only when its last cell holds a number that the
// serializer cannot yet take.
`default_nettype none

module binary_to_decimal_ascii (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_out_char,
   output logic             rsp_last
);

   localparam int Cells = b2da_pkg::NumBits;

   logic                    chain_valid [Cells+1];
   b2da_pkg::cell_data_type chain_data  [Cells+1];
   logic                    enable;
   logic                    emit_ready;
   logic                    feed_neg;

   // Advance the chain unless its last cell waits on the serializer
   assign enable    = !chain_valid[Cells] || emit_ready;
   assign req_ready = enable;

   // Feed the first cell with the magnitude and the sign flag
   assign feed_neg       = req_func && req_value[31];
   assign chain_valid[0] = req_valid;
   assign chain_data[0]  = '{neg: feed_neg,
                             bcd: '0,
                             bin: feed_neg ? (~req_value + 32'd1) : req_value};

   for (genvar g = 0; g < Cells; g++) begin : g_cell
      b2da_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   b2da_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[Cells]),
      .in_ready     (emit_ready),
      .in_data      (chain_data[Cells]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

### sv/b2da_check.sv
// Port checker for the converter and its bind to the top level.
`default_nettype none

module b2da_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_func,
   input wire logic [31:0] req_value,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [6:0]  rsp_out_char,
   input wire logic        rsp_last
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("stalled response changed");

   // Send only a minus that is never last, or a digit
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == b2da_pkg::CharMinus && !rsp_last)
                 || (rsp_out_char >= b2da_pkg::CharZero
                     && rsp_out_char <= b2da_pkg::CharZero + 7'd9))
      else $error("illegal character");

   // Follow a taken character that is not last with the next one at once
   a_rsp_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a number");

   // Drop any response after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind binary_to_decimal_ascii b2da_check u_check (.*);

`default_nettype wire

### bench/decimal_text_checker.sv
// Checker for the binary to decimal ASCII converter: predicts each request's text and compares.

module decimal_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [6:0]  rsp_out_char,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          chars_outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } text_char_type;

   // Characters still owed by the block, oldest first
   text_char_type pending_text[$];

   // Append the decimal text of one request, most significant character first
   function automatic void predict_text(input logic func, input logic [31:0] value);
      logic [31:0]   magnitude;
      logic [3:0]    digit_seq[10];
      int            count;
      text_char_type item;
      magnitude = value;
      count = 0;
      if (func && value[31]) begin
         magnitude = 32'd0 - value;
         item.code = b2da_pkg::CharMinus;
         item.last = 1'b0;
         pending_text.push_back(item);
      end
      // peel digits from the low end, at least one
      do begin
         digit_seq[count] = 4'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         count++;
      end while (magnitude != 32'd0);
      for (int i = count - 1; i >= 0; i--) begin
         item.code = b2da_pkg::CharZero + 7'(digit_seq[i]);
         item.last = (i == 0);
         pending_text.push_back(item);
      end
   endfunction

   // Check responses against the oldest prediction, then record new requests
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         pending_text.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_text.size() == 0) begin
               $display("%0t: unexpected character %0d last %0b", $time, rsp_out_char, rsp_last);
               mismatch_count++;
            end else begin
               want = pending_text.pop_front();
               if (rsp_out_char !== want.code) begin
                  $display("%0t: out_char expected %0d actual %0d",
                           $time, want.code, rsp_out_char);
                  mismatch_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_text(req_func, req_value);
      end
      chars_outstanding = pending_text.size();
   end

endmodule

### bench/tb_binary_to_decimal_ascii.sv
// Top of the converter testbench: clock, reset, request and response stimulus, verdict.

module tb_binary_to_decimal_ascii;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomWords = 200;
   localparam int CycleLimit  = 500000;
   localparam int DrainCycles = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [6:0]  rsp_out_char;
   logic        rsp_last;
   int          mismatch_count;
   int          chars_outstanding;
   int          cycle_count = 0;
   int          tx_steady = 0;

   binary_to_decimal_ascii DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

   decimal_text_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_char      (rsp_out_char),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .chars_outstanding (chars_outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_binary_to_decimal_ascii: errors");
         $finish;
      end
   end

   // Idle cycles before a request: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (tx_steady > 0) begin
         tx_steady--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         tx_steady = $urandom_range(10, 30);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Words spread over every text length and both sign edges
   function automatic logic [31:0] random_word();
      logic [31:0] pow;
      pow = 32'd1;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         2: begin
            repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
            return pow + $urandom_range(0, 2) - 32'd1;
         end
         3: return 32'd0 - $urandom_range(0, 1000);
         4: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                       : 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 99);
      endcase
   endfunction

   // Offer one request and hold it until accepted; returns at the next falling edge
   task automatic offer_word(input logic func, input logic [31:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func  = func;
      req_value = value;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Response side: random stalls, steady stretches, and one long hold-off
   initial begin
      int rx_cycle;
      int rx_hold;
      int rx_steady;
      int r;
      rx_cycle  = 0;
      rx_hold   = 0;
      rx_steady = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rx_cycle++;
         if (rx_cycle == 600) rx_hold = 400;
         if (rx_hold > 0) begin
            rsp_ready = 1'b0;
            rx_hold--;
         end else if (rx_steady > 0) begin
            rsp_ready = 1'b1;
            rx_steady--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               rx_steady = $urandom_range(20, 80);
               rsp_ready = 1'b1;
            end else if (r < 12) begin
               rx_hold = $urandom_range(9, 39);
               rsp_ready = 1'b0;
            end else if (r < 35) begin
               rsp_ready = 1'b0;
            end else begin
               rsp_ready = 1'b1;
            end
         end
         @(negedge clock);
      end
   end

   // Request side: directed words, then random ones, then drain and verdict
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero and one in both modes
      offer_word(1'b0, 32'd0);
      offer_word(1'b1, 32'd0);
      offer_word(1'b0, 32'd1);
      offer_word(1'b1, 32'd1);
      // all ones: largest unsigned, minus one signed
      offer_word(1'b0, 32'hFFFF_FFFF);
      offer_word(1'b1, 32'hFFFF_FFFF);
      // most negative word and its neighbors
      offer_word(1'b1, 32'h8000_0000);
      offer_word(1'b0, 32'h8000_0000);
      offer_word(1'b1, 32'h8000_0001);
      offer_word(1'b1, 32'h7FFF_FFFF);
      offer_word(1'b0, 32'h7FFF_FFFF);
      // digit count boundaries
      offer_word(1'b0, 32'd9);
      offer_word(1'b0, 32'd10);
      offer_word(1'b1, 32'd100);
      offer_word(1'b0, 32'd999999999);
      offer_word(1'b0, 32'd1000000000);
      offer_word(1'b0, 32'd4000000000);
      offer_word(1'b1, 32'd1234567890);
      // negatives with zeros inside the magnitude
      offer_word(1'b1, 32'hFFFF_FFF6);
      offer_word(1'b1, 32'hC465_3600);
      offer_word(1'b1, 32'hFFFE_7960);

      for (int i = 0; i < RandomWords; i++)
         offer_word(1'($urandom_range(0, 1)), random_word());
      req_valid = 1'b0;

      while (chars_outstanding != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_binary_to_decimal_ascii: clean");
      end else begin
         $display("tb_binary_to_decimal_ascii: errors");
      end
      $finish;
   end

endmodule
